// File: hdl/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the API frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

   // Frame delimiter and the value that a good checksum sums to.
   localparam logic [7:0] DELIM_BYTE       = 8'h7E;
   localparam logic [7:0] GOOD_SUM         = 8'hFF;
   localparam logic [7:0] SCAN_LIMIT_RESET = 8'd30;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // Configuration register word indexes.
   localparam logic REG_SCAN_LIMIT = 1'b0;

   typedef struct packed {
      logic [7:0] frame_type;
      logic [7:0] frame_length;
      logic [7:0] byte_index;
      logic [7:0] payload_byte;
      logic [1:0] kind;
   } afd_result_type;

endpackage

// File: hdl/afd_csr.sv
// ----------------------------------------------------------------------------
// afd_csr
// Register file of the deframer: holds the scan limit behind an APB port.
// ----------------------------------------------------------------------------
module afd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  scan_limit
);

   logic [7:0] scan_limit_ff;
   logic [7:0] scan_limit_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      scan_limit_in = scan_limit_ff;
      if (wr_en && (paddr[2] == afd_pkg::REG_SCAN_LIMIT)) begin
         scan_limit_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= afd_pkg::SCAN_LIMIT_RESET;
      end else begin
         scan_limit_ff <= scan_limit_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == afd_pkg::REG_SCAN_LIMIT) begin
         prdata = {24'd0, scan_limit_ff};
      end
   end

   assign scan_limit = scan_limit_ff;

endmodule

// File: hdl/afd_core.sv
// ----------------------------------------------------------------------------
// afd_core
// Frame state machine: consumes one byte per accepted word, updates the
// frame state and produces at most one result in the same cycle.
// ----------------------------------------------------------------------------
module afd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_accept,
   input  logic [7:0]              rx_byte,
   input  logic                    begin_req,
   input  logic [7:0]              scan_limit,
   output logic                    res_valid,
   output afd_pkg::afd_result_type res_data
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HUNT    = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK   = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] scan_count_ff, scan_count_in;
   logic [7:0] frame_len_ff, frame_len_in;
   logic [7:0] payload_pos_ff, payload_pos_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] type_byte_ff, type_byte_in;

   // State as seen after a begin request has cleared the frame.
   logic [2:0] cur_phase;
   logic [7:0] cur_scan, cur_len, cur_pos, cur_sum, cur_type;
   logic [7:0] pos_inc, sum_add;

   always_comb begin
      cur_phase = begin_req ? PH_HUNT : phase_ff;
      cur_scan  = begin_req ? 8'd0 : scan_count_ff;
      cur_len   = begin_req ? 8'd0 : frame_len_ff;
      cur_pos   = begin_req ? 8'd0 : payload_pos_ff;
      cur_sum   = begin_req ? 8'd0 : running_sum_ff;
      cur_type  = begin_req ? 8'd0 : type_byte_ff;
      pos_inc   = cur_pos + 8'd1;
      sum_add   = cur_sum + rx_byte;

      phase_in       = cur_phase;
      scan_count_in  = cur_scan;
      frame_len_in   = cur_len;
      payload_pos_in = cur_pos;
      running_sum_in = cur_sum;
      type_byte_in   = cur_type;
      res_valid      = 1'b0;
      res_data       = '0;

      unique case (cur_phase)
         PH_HUNT: begin
            if (rx_byte == afd_pkg::DELIM_BYTE) begin
               phase_in = PH_LEN_HI;
            end else if (cur_scan > scan_limit) begin
               phase_in      = PH_IDLE;
               res_valid     = 1'b1;
               res_data.kind = afd_pkg::KIND_TIMEOUT;
            end else if (cur_scan != 8'hFF) begin
               scan_count_in = cur_scan + 8'd1;
            end
         end
         PH_LEN_HI: begin
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len_in   = rx_byte;
            payload_pos_in = 8'd0;
            running_sum_in = 8'd0;
            type_byte_in   = 8'd0;
            phase_in       = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (cur_pos == 8'd0) begin
               type_byte_in = rx_byte;
            end
            running_sum_in = sum_add;
            payload_pos_in = pos_inc;
            if (pos_inc >= cur_len) begin
               phase_in = PH_CHECK;
            end
            res_valid             = 1'b1;
            res_data.kind         = afd_pkg::KIND_PAYLOAD;
            res_data.payload_byte = rx_byte;
            res_data.byte_index   = cur_pos;
            res_data.frame_length = cur_len;
            res_data.frame_type   = (cur_pos == 8'd0) ? rx_byte : cur_type;
         end
         PH_CHECK: begin
            phase_in              = PH_IDLE;
            res_valid             = 1'b1;
            res_data.kind         = (sum_add == afd_pkg::GOOD_SUM) ?
                                    afd_pkg::KIND_GOOD : afd_pkg::KIND_BAD;
            res_data.frame_length = cur_len;
            res_data.frame_type   = cur_type;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (!in_accept) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         scan_count_ff  <= 8'd0;
         frame_len_ff   <= 8'd0;
         payload_pos_ff <= 8'd0;
         running_sum_ff <= 8'd0;
         type_byte_ff   <= 8'd0;
      end else if (in_accept) begin
         phase_ff       <= phase_in;
         scan_count_ff  <= scan_count_in;
         frame_len_ff   <= frame_len_in;
         payload_pos_ff <= payload_pos_in;
         running_sum_ff <= running_sum_in;
         type_byte_ff   <= type_byte_in;
      end
   end

endmodule

// File: hdl/afd_obuf.sv
// ----------------------------------------------------------------------------
// afd_obuf
// Result register with a skid stage, so the input side keeps flowing for one
// extra word while the result side stalls.
// ----------------------------------------------------------------------------
module afd_obuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  afd_pkg::afd_result_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output afd_pkg::afd_result_type out_data,
   input  logic                    out_ready
);

   logic                    out_valid_ff, out_valid_in;
   afd_pkg::afd_result_type out_data_ff, out_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   afd_pkg::afd_result_type skid_data_ff, skid_data_in;

   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// File: hdl/api_frame_deframer.sv
// ----------------------------------------------------------------------------
// api_frame_deframer
// Receiver for delimited, length-prefixed, checksummed radio-module frames.
// ----------------------------------------------------------------------------
// The block takes one received byte per word and accepts a word in every
// cycle while the result side keeps up: each word is handled in the cycle it
// is accepted, and its result, if any, goes to the output register, or to
// the skid on a stall. A two-deep result stage (output register plus skid
// register) lets the input side take one more word while a result waits;
// only when both are full does req_tready drop. A word with begin_req set
// starts a new read attempt, and its byte is already the first hunting byte.
// While hunting, bytes other than 0x7E are counted and a timeout result is
// given once the count has exceeded the scan limit register. After the
// delimiter the length high byte is skipped, the low byte gives the payload
// length, each payload byte is reported with its index, and the checksum byte
// ends the frame with a good or bad result. Bytes arriving while idle are
// dropped. The scan limit should be written only while the block is idle.
module api_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] begin_req
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                    // [23:16] frame_length, [31:24] frame_type
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                    in_accept;
   logic [7:0]              scan_limit;
   logic                    res_valid;
   afd_pkg::afd_result_type res_data;
   afd_pkg::afd_result_type rsp_data;

   // A valid word is taken whenever the skid register is free.
   assign in_accept = req_tvalid && req_tready;

   afd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .scan_limit (scan_limit)
   );

   afd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .rx_byte    (req_tdata),
      .begin_req  (req_tuser),
      .scan_limit (scan_limit),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   afd_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   // Pack the result fields, lowest field in the lowest bits.
   assign rsp_tdata = {rsp_data.frame_type, rsp_data.frame_length,
                       rsp_data.byte_index, rsp_data.payload_byte};
   assign rsp_tuser = rsp_data.kind;

endmodule
